@@ design/mcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared widths, opcodes and octant codes for the circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Default parameter values of the top level.
    localparam int MCR_COORD_BITS  = 12;
    localparam int MCR_RADIUS_BITS = 10;

    // Fixed widths of the result item.
    localparam int MCR_PIX_BITS   = 13;
    localparam int MCR_COLOR_BITS = 8;

    // Input item opcodes.
    localparam logic MCR_OP_START = 1'b0;
    localparam logic MCR_OP_NEXT  = 1'b1;

    // Octant sequence codes; the step of the offsets follows the last one.
    localparam logic [2:0] MCR_OCT_FIRST = 3'd0;
    localparam logic [2:0] MCR_OCT_LAST  = 3'd7;

endpackage

@@ design/midpoint_circle_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Emits the eight-way symmetric outline of a circle, one pixel per next item.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------
//   in      | input     | in_valid / in_stall       | opcode, center, radius, color
//   out     | output    | out_valid / out_stall     | pixel_x/y, pix color, last_pixel
//
// Each item is handled in its accept cycle: one item per cycle while not stalled.
// The circle state and the result register are the only pipeline stage.
// Reset (rst_n low) makes the block idle and empties the result register.
// in_stall is high only while a result waits in the result register and
// out_stall holds it there; a drained result frees the input the same cycle.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
    parameter int COORD_BITS  = mcr_pkg::MCR_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::MCR_RADIUS_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Input channel
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     opcode,
    input  logic signed [COORD_BITS-1:0]             center_x,
    input  logic signed [COORD_BITS-1:0]             center_y,
    input  logic        [RADIUS_BITS-1:0]            radius,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] red,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] green,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] blue,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] alpha,
    // Output channel
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_x,
    output logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_y,
    output logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_red,
    output logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_green,
    output logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_blue,
    output logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_alpha,
    output logic                                     last_pixel
);
    import mcr_pkg::*;

    // Offsets carry one extra bit so that a can reach -1.
    localparam int OFS_W = RADIUS_BITS + 1;
    // The decision error is kept in four bits more than the radius width.
    localparam int ERR_W = RADIUS_BITS + 4;
    // Pixel sums are exact in this width; the result keeps the low bits.
    localparam int SUM_A = (COORD_BITS > RADIUS_BITS) ? COORD_BITS + 2 : RADIUS_BITS + 3;
    localparam int SUM_W = (SUM_A > MCR_PIX_BITS) ? SUM_A : MCR_PIX_BITS;

    localparam logic signed [OFS_W-1:0] OFS_ONE = OFS_W'(1);
    localparam logic signed [ERR_W-1:0] ERR_ONE = ERR_W'(1);
    localparam logic signed [ERR_W-1:0] ERR_TWO = ERR_W'(2);

    // Circle state.
    logic                       active_reg, active_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [OFS_W-1:0]    a_reg, a_next;
    logic signed [OFS_W-1:0]    b_reg, b_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic [2:0]                 oct_reg, oct_next;
    logic [MCR_COLOR_BITS-1:0]  red_reg, red_next;
    logic [MCR_COLOR_BITS-1:0]  green_reg, green_next;
    logic [MCR_COLOR_BITS-1:0]  blue_reg, blue_next;
    logic [MCR_COLOR_BITS-1:0]  alpha_reg, alpha_next;

    // Result register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [MCR_PIX_BITS-1:0] px_reg, px_next;
    logic signed [MCR_PIX_BITS-1:0] py_reg, py_next;
    logic [MCR_COLOR_BITS-1:0]  ored_reg, ored_next;
    logic [MCR_COLOR_BITS-1:0]  ogreen_reg, ogreen_next;
    logic [MCR_COLOR_BITS-1:0]  oblue_reg, oblue_next;
    logic [MCR_COLOR_BITS-1:0]  oalpha_reg, oalpha_next;
    logic                       last_reg, last_next;

    // Datapath signals.
    logic                       accept;
    logic                       emit;
    logic signed [OFS_W-1:0]    sel_x;
    logic signed [OFS_W-1:0]    sel_y;
    logic signed [SUM_W-1:0]    sum_x;
    logic signed [SUM_W-1:0]    sum_y;
    logic signed [ERR_W-1:0]    err_add;
    logic signed [ERR_W-1:0]    err_sub;
    logic signed [OFS_W-1:0]    b_inc;
    logic signed [OFS_W-1:0]    a_dec;
    logic signed [OFS_W-1:0]    a_new;
    logic                       step_last;

    // The input is held off only while a result waits and is stalled.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign emit     = accept & (opcode == MCR_OP_NEXT) & active_reg;

    // Offset selection per octant; -v-1 is the bitwise complement of v.
    always_comb
    begin
        case (oct_reg)
            3'd0:    begin sel_x = a_reg;  sel_y = b_reg;  end
            3'd1:    begin sel_x = b_reg;  sel_y = a_reg;  end
            3'd2:    begin sel_x = ~a_reg; sel_y = b_reg;  end
            3'd3:    begin sel_x = b_reg;  sel_y = ~a_reg; end
            3'd4:    begin sel_x = a_reg;  sel_y = ~b_reg; end
            3'd5:    begin sel_x = ~b_reg; sel_y = a_reg;  end
            3'd6:    begin sel_x = ~a_reg; sel_y = ~b_reg; end
            default: begin sel_x = ~b_reg; sel_y = ~a_reg; end
        endcase
    end

    // Pixel coordinates, wrapped to the result width.
    assign sum_x = SUM_W'(cx_reg) + SUM_W'(sel_x);
    assign sum_y = SUM_W'(cy_reg) + SUM_W'(sel_y);

    // Midpoint step taken after the eighth pixel of a pair of offsets.
    assign err_add   = err_reg + (ERR_W'(b_reg) <<< 1) + ERR_TWO;
    assign b_inc     = b_reg + OFS_ONE;
    assign a_dec     = a_reg - OFS_ONE;
    assign err_sub   = err_add - (ERR_W'(a_dec) <<< 1) - ERR_ONE;
    assign a_new     = err_add[ERR_W-1] ? a_reg : a_dec;
    assign step_last = (a_new < b_inc);

    // Next state of the circle.
    always_comb
    begin
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        err_next    = err_reg;
        oct_next    = oct_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        alpha_next  = alpha_reg;
        if (accept && (opcode == MCR_OP_START))
        begin
            active_next = (radius != '0);
            cx_next     = center_x;
            cy_next     = center_y;
            a_next      = signed'({1'b0, radius}) - OFS_ONE;
            b_next      = '0;
            err_next    = -signed'(ERR_W'(radius));
            oct_next    = MCR_OCT_FIRST;
            red_next    = red;
            green_next  = green;
            blue_next   = blue;
            alpha_next  = alpha;
        end
        else if (emit)
        begin
            if (oct_reg == MCR_OCT_LAST)
            begin
                a_next      = a_new;
                b_next      = b_inc;
                err_next    = err_add[ERR_W-1] ? err_add : err_sub;
                oct_next    = MCR_OCT_FIRST;
                active_next = ~step_last;
            end
            else
            begin
                oct_next = oct_reg + 3'd1;
            end
        end
    end

    // Next contents of the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        ored_next      = ored_reg;
        ogreen_next    = ogreen_reg;
        oblue_next     = oblue_reg;
        oalpha_next    = oalpha_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            px_next        = sum_x[MCR_PIX_BITS-1:0];
            py_next        = sum_y[MCR_PIX_BITS-1:0];
            ored_next      = red_reg;
            ogreen_next    = green_reg;
            oblue_next     = blue_reg;
            oalpha_next    = alpha_reg;
            last_next      = (oct_reg == MCR_OCT_LAST) & step_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            oct_reg       <= MCR_OCT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            oct_reg       <= oct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        err_reg    <= err_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        alpha_reg  <= alpha_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ored_reg   <= ored_next;
        ogreen_reg <= ogreen_next;
        oblue_reg  <= oblue_next;
        oalpha_reg <= oalpha_next;
        last_reg   <= last_next;
    end

    // Output ports.
    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign pix_red    = ored_reg;
    assign pix_green  = ogreen_reg;
    assign pix_blue   = oblue_reg;
    assign pix_alpha  = oalpha_reg;
    assign last_pixel = last_reg;

endmodule

@@ design/mcr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer checker
// Port-level assertions on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker #(
    parameter int COORD_BITS  = mcr_pkg::MCR_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::MCR_RADIUS_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic                                     in_stall,
    input  logic                                     opcode,
    input  logic signed [COORD_BITS-1:0]             center_x,
    input  logic signed [COORD_BITS-1:0]             center_y,
    input  logic        [RADIUS_BITS-1:0]            radius,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] red,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] green,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] blue,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] alpha,
    input  logic                                     out_valid,
    input  logic                                     out_stall,
    input  logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_x,
    input  logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_y,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_red,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_green,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_blue,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_alpha,
    input  logic                                     last_pixel
);
    import mcr_pkg::*;

    logic in_acc;
    assign in_acc = in_valid & ~in_stall;

    // A stalled result item stays valid and holds its coordinates, red value and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pix_red) && $stable(last_pixel)))
    else $error("stalled result item changed");

    // The input is only held off by a waiting result item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with no result pending");

    // A start item never produces a result item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && opcode == MCR_OP_START) |=> !out_valid)
    else $error("result item after start");

    // A next item that directly follows a zero-radius start draws no pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && opcode == MCR_OP_START && radius == '0) ##1 (in_acc && opcode == MCR_OP_NEXT)
            |=> !out_valid)
    else $error("pixel emitted for zero radius");

    // The first pixel of a circle is never its last and carries the new red and alpha values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && opcode == MCR_OP_START && radius != '0) ##1 (in_acc && opcode == MCR_OP_NEXT)
            |=> (out_valid && !last_pixel && pix_red == $past(red, 2)
                && pix_alpha == $past(alpha, 2)))
    else $error("first pixel of circle is wrong");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_mcr_checker (.*);

@@ dv/midpoint_circle_rasterizer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer checker
// Watches both channels of the rasterizer, traces each circle outline on its
// own copy of the circle state and compares every emitted pixel, field by
// field, with the oldest pixel that it still waits for.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_checker #(
    parameter int COORD_BITS  = mcr_pkg::MCR_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::MCR_RADIUS_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Input channel
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic                                      opcode,
    input  logic signed [COORD_BITS-1:0]              center_x,
    input  logic signed [COORD_BITS-1:0]              center_y,
    input  logic        [RADIUS_BITS-1:0]             radius,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] red,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] green,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] blue,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] alpha,
    // Output channel
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_x,
    input  logic signed [mcr_pkg::MCR_PIX_BITS-1:0]   pixel_y,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_red,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_green,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_blue,
    input  logic        [mcr_pkg::MCR_COLOR_BITS-1:0] pix_alpha,
    input  logic                                      last_pixel,
    // Status
    output int                                        errors,
    output int                                        pending
);
    import mcr_pkg::*;

    // The eight symmetric points of one (a,b) pair, in emission order.
    typedef enum logic [2:0] {
        OCT_A_B   = MCR_OCT_FIRST,
        OCT_B_A,
        OCT_NA_B,
        OCT_B_NA,
        OCT_A_NB,
        OCT_NB_A,
        OCT_NA_NB,
        OCT_NB_NA
    } octant_t;

    typedef struct {
        logic signed [MCR_PIX_BITS-1:0]   x;
        logic signed [MCR_PIX_BITS-1:0]   y;
        logic        [MCR_COLOR_BITS-1:0] r;
        logic        [MCR_COLOR_BITS-1:0] g;
        logic        [MCR_COLOR_BITS-1:0] b;
        logic        [MCR_COLOR_BITS-1:0] a;
        logic                             last;
    } outline_pixel_t;

    // Pixels predicted but not yet seen on the output, oldest first.
    outline_pixel_t outline_queue[$];

    // Circle state as the block should hold it.
    logic                      drawing;
    int                        ctr_col;
    int                        ctr_row;
    int                        major;
    int                        minor;
    int                        decision;
    octant_t                   octant;
    logic [MCR_COLOR_BITS-1:0] col_r;
    logic [MCR_COLOR_BITS-1:0] col_g;
    logic [MCR_COLOR_BITS-1:0] col_b;
    logic [MCR_COLOR_BITS-1:0] col_a;

    // A start item loads the circle; a next item traces one outline pixel.
    task automatic trace_item(input logic op, input int cx, input int cy, input int rad,
                              input logic [MCR_COLOR_BITS-1:0] cr,
                              input logic [MCR_COLOR_BITS-1:0] cg,
                              input logic [MCR_COLOR_BITS-1:0] cb,
                              input logic [MCR_COLOR_BITS-1:0] ca);
        outline_pixel_t pix;
        int px;
        int py;
        if (op == MCR_OP_START)
        begin
            ctr_col  = cx;
            ctr_row  = cy;
            major    = rad - 1;
            minor    = 0;
            decision = -rad;
            octant   = OCT_A_B;
            col_r    = cr;
            col_g    = cg;
            col_b    = cb;
            col_a    = ca;
            drawing  = (rad != 0);
        end
        else if (drawing)
        begin
            case (octant)
                OCT_A_B:   begin px = ctr_col + major;     py = ctr_row + minor;     end
                OCT_B_A:   begin px = ctr_col + minor;     py = ctr_row + major;     end
                OCT_NA_B:  begin px = ctr_col - major - 1; py = ctr_row + minor;     end
                OCT_B_NA:  begin px = ctr_col + minor;     py = ctr_row - major - 1; end
                OCT_A_NB:  begin px = ctr_col + major;     py = ctr_row - minor - 1; end
                OCT_NB_A:  begin px = ctr_col - minor - 1; py = ctr_row + major;     end
                OCT_NA_NB: begin px = ctr_col - major - 1; py = ctr_row - minor - 1; end
                default:   begin px = ctr_col - minor - 1; py = ctr_row - major - 1; end
            endcase
            pix.x    = px[MCR_PIX_BITS-1:0];
            pix.y    = py[MCR_PIX_BITS-1:0];
            pix.r    = col_r;
            pix.g    = col_g;
            pix.b    = col_b;
            pix.a    = col_a;
            pix.last = 1'b0;
            // After the eighth point the offsets take one midpoint step.
            if (octant == MCR_OCT_LAST)
            begin
                decision += 2 * minor + 2;
                minor    += 1;
                if (decision >= 0)
                begin
                    major    -= 1;
                    decision -= 2 * major + 1;
                end
                octant = OCT_A_B;
                if (major < minor)
                begin
                    pix.last = 1'b1;
                    drawing  = 1'b0;
                end
            end
            else
            begin
                octant = octant_t'(octant + 3'd1);
            end
            outline_queue.push_back(pix);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compares one emitted pixel with the oldest prediction.
    task automatic check_pixel();
        outline_pixel_t want;
        if (outline_queue.size() == 0)
        begin
            $display("%0t: pixel (%0d,%0d) emitted, expected no pixel",
                     $time, pixel_x, pixel_y);
            errors++;
        end
        else
        begin
            want = outline_queue.pop_front();
            compare_field("pixel_x", want.x, pixel_x);
            compare_field("pixel_y", want.y, pixel_y);
            compare_field("pix_red", want.r, pix_red);
            compare_field("pix_green", want.g, pix_green);
            compare_field("pix_blue", want.b, pix_blue);
            compare_field("pix_alpha", want.a, pix_alpha);
            compare_field("last_pixel", want.last, last_pixel);
        end
    endtask

    // Outputs are checked before the new item is traced, since a pixel seen at
    // this edge always comes from an item accepted at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing  = 1'b0;
            ctr_col  = 0;
            ctr_row  = 0;
            major    = 0;
            minor    = 0;
            decision = 0;
            octant   = OCT_A_B;
            col_r    = '0;
            col_g    = '0;
            col_b    = '0;
            col_a    = '0;
            errors   = 0;
            outline_queue.delete();
            pending  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_pixel();
            if (in_valid && !in_stall)
                trace_item(opcode, center_x, center_y, radius, red, green, blue, alpha);
            pending = outline_queue.size();
        end
    end

endmodule

@@ dv/midpoint_circle_rasterizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Drives short directed circles and then mostly complete random circles, mixed
// with abandoned circles, zero radii and next items while idle, under random
// idling on both channels. The checker beside the block scores every pixel.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit_tb;
    import mcr_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 60;
    localparam int TIMEOUT_NS  = 10_000_000;
    localparam int MAX_RADIUS  = (1 << MCR_RADIUS_BITS) - 1;
    localparam int BIG_RADIUS  = 96;
    localparam logic signed [MCR_COORD_BITS-1:0] COORD_MAX =
        MCR_COORD_BITS'((1 << (MCR_COORD_BITS - 1)) - 1);
    localparam logic signed [MCR_COORD_BITS-1:0] COORD_MIN =
        MCR_COORD_BITS'(-(1 << (MCR_COORD_BITS - 1)));

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic                                  opcode;
    logic signed [MCR_COORD_BITS-1:0]      center_x;
    logic signed [MCR_COORD_BITS-1:0]      center_y;
    logic        [MCR_RADIUS_BITS-1:0]     radius;
    logic        [MCR_COLOR_BITS-1:0]      red;
    logic        [MCR_COLOR_BITS-1:0]      green;
    logic        [MCR_COLOR_BITS-1:0]      blue;
    logic        [MCR_COLOR_BITS-1:0]      alpha;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [MCR_PIX_BITS-1:0]        pixel_x;
    logic signed [MCR_PIX_BITS-1:0]        pixel_y;
    logic        [MCR_COLOR_BITS-1:0]      pix_red;
    logic        [MCR_COLOR_BITS-1:0]      pix_green;
    logic        [MCR_COLOR_BITS-1:0]      pix_blue;
    logic        [MCR_COLOR_BITS-1:0]      pix_alpha;
    logic                                  last_pixel;

    int   mismatch_count;
    int   pixels_pending;
    int   closed_circles = 0;
    int   items_sent;
    int   gap_pct;
    logic quiet;

    midpoint_circle_rasterizer_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pix_red    (pix_red),
        .pix_green  (pix_green),
        .pix_blue   (pix_blue),
        .pix_alpha  (pix_alpha),
        .last_pixel (last_pixel)
    );

    midpoint_circle_rasterizer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pix_red    (pix_red),
        .pix_green  (pix_green),
        .pix_blue   (pix_blue),
        .pix_alpha  (pix_alpha),
        .last_pixel (last_pixel),
        .errors     (mismatch_count),
        .pending    (pixels_pending)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Counts finished circles so that the driver knows when to move on.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall && last_pixel)
            closed_circles <= closed_circles + 1;
    end

    function automatic logic signed [MCR_COORD_BITS-1:0] rand_coord();
        return MCR_COORD_BITS'($urandom);
    endfunction

    // Offers one item after an optional idle burst and waits until it is taken.
    task automatic push_item(input logic op,
                             input logic signed [MCR_COORD_BITS-1:0] cx,
                             input logic signed [MCR_COORD_BITS-1:0] cy,
                             input logic [MCR_RADIUS_BITS-1:0] rad,
                             input logic [31:0] rgba);
        int idle;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            idle = $urandom_range(1, 8);
            repeat (idle)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        center_x <= cx;
        center_y <= cy;
        radius   <= rad;
        red      <= rgba[31:24];
        green    <= rgba[23:16];
        blue     <= rgba[15:8];
        alpha    <= rgba[7:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // A next item; its other fields are ignored by the block, so they toggle.
    task automatic next_pixel();
        push_item(MCR_OP_NEXT, rand_coord(), rand_coord(), MCR_RADIUS_BITS'($urandom),
                  $urandom);
    endtask

    // Starts a circle and asks for pixels until it closes or the cap is hit.
    task automatic draw_circle(input logic signed [MCR_COORD_BITS-1:0] cx,
                               input logic signed [MCR_COORD_BITS-1:0] cy,
                               input int rad, input logic [31:0] rgba,
                               input int max_nexts);
        int seen;
        int n;
        push_item(MCR_OP_START, cx, cy, MCR_RADIUS_BITS'(rad), rgba);
        seen = closed_circles;
        n    = 0;
        while (closed_circles == seen && n < max_nexts)
        begin
            next_pixel();
            n++;
        end
    endtask

    // Result side: random stall bursts, one long hold-off, none at the end.
    initial
    begin : result_sink
        int   cyc;
        int   hold_left;
        int   busy_pct;
        logic stall_now;
        out_stall = 1'b0;
        cyc       = 0;
        hold_left = 0;
        busy_pct  = 15;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       busy_pct = 0;
                    1:       busy_pct = 15;
                    default: busy_pct = 40;
                endcase
            end
            if (cyc == HOLD_AT)
            begin
                hold_left = HOLD_LEN - 1;
                stall_now = 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < busy_pct)
            begin
                hold_left = $urandom_range(0, 7);
                stall_now = 1'b1;
            end
            else
            begin
                stall_now = 1'b0;
            end
            out_stall <= stall_now;
        end
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int   kind;
        int   rad;
        logic big_done;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = MCR_OP_NEXT;
        center_x   = '0;
        center_y   = '0;
        radius     = '0;
        red        = '0;
        green      = '0;
        blue       = '0;
        alpha      = '0;
        quiet      = 1'b0;
        gap_pct    = 20;
        items_sent = 0;
        big_done   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: next while idle, zero radius, corner centers with extreme
        // colors, and a circle restarted while still in progress.
        next_pixel();
        push_item(MCR_OP_START, COORD_MAX, COORD_MIN, '0, 32'hFFFF_FFFF);
        next_pixel();
        draw_circle(COORD_MAX, COORD_MAX, 1, 32'hFFFF_FFFF, 16);
        draw_circle(COORD_MIN, COORD_MIN, 3, 32'h0000_0000, 3);
        draw_circle('0, '0, 2, 32'h1234_5678, 32);

        // Random: mostly whole small circles, some abandoned large ones,
        // zero radii and stray next items.
        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent >= ITEM_TARGET * 85 / 100);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            kind = $urandom_range(0, 99);
            if (!big_done && items_sent >= ITEM_TARGET / 2)
            begin
                // One full circle of a larger radius at a corner center.
                big_done = 1'b1;
                draw_circle(COORD_MIN, COORD_MAX, BIG_RADIUS, $urandom, 8 * BIG_RADIUS + 16);
            end
            else if (kind < 70)
            begin
                rad = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                draw_circle(rand_coord(), rand_coord(), rad, $urandom, 8 * rad + 16);
            end
            else if (kind < 85)
            begin
                rad = $urandom_range(1, MAX_RADIUS);
                draw_circle(rand_coord(), rand_coord(), rad, $urandom, $urandom_range(0, 20));
            end
            else if (kind < 92)
            begin
                draw_circle(rand_coord(), rand_coord(), 0, $urandom, $urandom_range(1, 3));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) next_pixel();
            end
        end

        // Drain and decide.
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mcr_pkg.sv
design/midpoint_circle_rasterizer_unit.sv
design/mcr_checker.sv
dv/midpoint_circle_rasterizer_checker.sv
dv/midpoint_circle_rasterizer_unit_tb.sv
